@@ src/mcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

    localparam int COORD_BITS = 10;
    localparam int PIX_BITS   = COORD_BITS + 2;
    localparam int DEC_BITS   = COORD_BITS + 3;
    localparam int OCTANTS    = 8;
    localparam int OCT_BITS   = $clog2(OCTANTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [OCT_BITS-1:0] OCT_LAST = OCT_BITS'(OCTANTS - 1);

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [COORD_BITS-1:0] radius;
    } cmd_t;

    typedef struct packed {
        logic signed [PIX_BITS-1:0] pixel_x;
        logic signed [PIX_BITS-1:0] pixel_y;
        logic                       last_of_step;
        logic                       circle_done;
    } pix_t;

    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } job_t;

endpackage

`default_nettype wire

@@ src/midpoint_circle_rasterizer_top.sv @@
// Midpoint circle rasterizer. A begin transaction (cmd 0) loads center and radius and
// returns the eight symmetric pixels of the first point; each step transaction (cmd 1)
// returns the next eight pixels, or a single done result once the octant is finished.
// Pixels leave one per cycle while pix_ready is high, the pixel generator stepping through
// the eight octants for a begin or step and giving one result for a done. The front
// updates the circle state in the cycle it accepts a transaction and hands the work to
// the pixel generator through a two-entry queue, so new commands are taken while earlier
// pixels are still draining. The first result passes through the queue slot, the job
// register and the output register.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_rasterizer_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire mcr_pkg::cmd_t cmd_data,
    output logic               pix_valid,
    input  wire logic          pix_ready,
    output mcr_pkg::pix_t      pix_data
);
    import mcr_pkg::*;

    logic q_push_valid, q_push_ready;
    logic q_pop_valid, q_pop_ready;
    job_t q_push_data, q_pop_data;

    mcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .job_valid (q_push_valid),
        .job_ready (q_push_ready),
        .job_data  (q_push_data)
    );

    mcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    mcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_pop_valid),
        .job_ready (q_pop_ready),
        .job_data  (q_pop_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data)
    );

endmodule

`default_nettype wire

@@ src/mcr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire mcr_pkg::cmd_t cmd_data,
    output logic               job_valid,
    input  wire logic          job_ready,
    output mcr_pkg::job_t      job_data
);
    import mcr_pkg::*;

    logic [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg, origin_y_next;
    logic [COORD_BITS-1:0] offset_x_reg, offset_x_next;
    logic [COORD_BITS-1:0] offset_y_reg, offset_y_next;
    logic [DEC_BITS-1:0]   decision_reg, decision_next;
    logic                  drawing_reg, drawing_next;

    logic                  accept;
    logic                  is_begin;
    logic                  emit;
    logic [COORD_BITS-1:0] cx_cur, cy_cur, x_cur, y_cur;
    logic [DEC_BITS-1:0]   dec_cur;
    logic [COORD_BITS-1:0] x_inc, y_dec;
    logic [DEC_BITS-1:0]   dec_adv;

    assign cmd_ready = job_ready;
    assign job_valid = cmd_valid;
    assign accept    = cmd_valid && job_ready;
    assign is_begin  = (cmd_data.cmd == CMD_BEGIN);

    always_comb
    begin
        if (is_begin)
        begin
            cx_cur  = cmd_data.center_x;
            cy_cur  = cmd_data.center_y;
            x_cur   = '0;
            y_cur   = cmd_data.radius;
            dec_cur = DEC_BITS'(1) - {3'b000, cmd_data.radius};
        end
        else
        begin
            cx_cur  = origin_x_reg;
            cy_cur  = origin_y_reg;
            x_cur   = offset_x_reg;
            y_cur   = offset_y_reg;
            dec_cur = decision_reg;
        end
    end

    assign emit  = is_begin || (drawing_reg && (offset_x_reg <= offset_y_reg));
    assign x_inc = x_cur + COORD_BITS'(1);
    assign y_dec = (y_cur != '0) ? (y_cur - COORD_BITS'(1)) : y_cur;

    always_comb
    begin
        if (dec_cur[DEC_BITS-1])
            dec_adv = dec_cur + {2'b00, x_inc, 1'b1};
        else
            dec_adv = dec_cur + {2'b00, x_inc, 1'b1} - {2'b00, y_dec, 1'b0};
    end

    always_comb
    begin
        job_data.done = !emit;
        job_data.cx   = cx_cur;
        job_data.cy   = cy_cur;
        job_data.x    = x_cur;
        job_data.y    = y_cur;
    end

    always_comb
    begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        decision_next = decision_reg;
        drawing_next  = drawing_reg;
        if (accept)
        begin
            if (emit)
            begin
                origin_x_next = cx_cur;
                origin_y_next = cy_cur;
                offset_x_next = x_inc;
                offset_y_next = dec_cur[DEC_BITS-1] ? y_cur : y_dec;
                decision_next = dec_adv;
                drawing_next  = 1'b1;
            end
            else
            begin
                drawing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            decision_reg <= '0;
            drawing_reg  <= 1'b0;
        end
        else
        begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            decision_reg <= decision_next;
            drawing_reg  <= drawing_next;
        end
    end

endmodule

`default_nettype wire

@@ src/mcr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire mcr_pkg::job_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output mcr_pkg::job_t      pop_data
);
    import mcr_pkg::*;

    job_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (QPTR_BITS + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (QPTR_BITS + 1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ src/mcr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire mcr_pkg::job_t job_data,
    output logic               pix_valid,
    input  wire logic          pix_ready,
    output mcr_pkg::pix_t      pix_data
);
    import mcr_pkg::*;

    logic                busy_reg, busy_next;
    job_t                job_reg, job_next;
    logic [OCT_BITS-1:0] idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    pix_t                out_reg, out_next;

    logic                can_load;
    logic                finishing;
    logic                take;
    logic [COORD_BITS-1:0] opnd_x, opnd_y;
    logic [PIX_BITS-1:0] cx_ext, cy_ext, ax_ext, ay_ext;
    pix_t                pix_cur;

    assign can_load  = !out_valid_reg || pix_ready;
    assign finishing = busy_reg && can_load && (job_reg.done || (idx_reg == OCT_LAST));
    assign take      = job_valid && (!busy_reg || finishing);
    assign job_ready = !busy_reg || finishing;

    // octant order: idx[2] swaps x/y, idx[1] negates column, idx[0] negates row
    assign opnd_x = idx_reg[2] ? job_reg.y : job_reg.x;
    assign opnd_y = idx_reg[2] ? job_reg.x : job_reg.y;
    assign cx_ext = {2'b00, job_reg.cx};
    assign cy_ext = {2'b00, job_reg.cy};
    assign ax_ext = {2'b00, opnd_x};
    assign ay_ext = {2'b00, opnd_y};

    always_comb
    begin
        if (job_reg.done)
        begin
            pix_cur.pixel_x      = '0;
            pix_cur.pixel_y      = '0;
            pix_cur.last_of_step = 1'b1;
            pix_cur.circle_done  = 1'b1;
        end
        else
        begin
            pix_cur.pixel_x      = idx_reg[1] ? (cx_ext - ax_ext) : (cx_ext + ax_ext);
            pix_cur.pixel_y      = idx_reg[0] ? (cy_ext - ay_ext) : (cy_ext + ay_ext);
            pix_cur.last_of_step = (idx_reg == OCT_LAST);
            pix_cur.circle_done  = 1'b0;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pix_ready)
            out_valid_next = 1'b0;
        if (busy_reg && can_load)
        begin
            out_valid_next = 1'b1;
            out_next       = pix_cur;
            idx_next       = idx_reg + OCT_BITS'(1);
            if (finishing)
                busy_next = 1'b0;
        end
        if (take)
        begin
            busy_next = 1'b1;
            job_next  = job_data;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix_data  = out_reg;

endmodule

`default_nettype wire

@@ tb/sv/circle_pixel_checker.sv @@
`timescale 1ns / 1ps

module circle_pixel_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_ready,
    input  mcr_pkg::cmd_t  cmd_data,
    input  logic           pix_valid,
    input  logic           pix_ready,
    input  mcr_pkg::pix_t  pix_data,
    output int             mismatches,
    output int             pending
);
    import mcr_pkg::*;

    logic [COORD_BITS-1:0]      org_x;
    logic [COORD_BITS-1:0]      org_y;
    logic [COORD_BITS-1:0]      off_x;
    logic [COORD_BITS-1:0]      off_y;
    logic signed [DEC_BITS-1:0] dec_val;
    logic                       drawing;
    pix_t                       expected_pixels[$];

    task automatic push_pixel(input int px, input int py, input logic last);
        pix_t p;
        p.pixel_x      = PIX_BITS'(px);
        p.pixel_y      = PIX_BITS'(py);
        p.last_of_step = last;
        p.circle_done  = 1'b0;
        expected_pixels.push_back(p);
    endtask

    // eight symmetric pixels of the current point, then one midpoint update
    task automatic plot_and_advance();
        int cx;
        int cy;
        int x;
        int y;
        int nx;
        int d;
        cx = org_x;
        cy = org_y;
        x  = off_x;
        y  = off_y;
        push_pixel(cx + x, cy + y, 1'b0);
        push_pixel(cx + x, cy - y, 1'b0);
        push_pixel(cx - x, cy + y, 1'b0);
        push_pixel(cx - x, cy - y, 1'b0);
        push_pixel(cx + y, cy + x, 1'b0);
        push_pixel(cx + y, cy - x, 1'b0);
        push_pixel(cx - y, cy + x, 1'b0);
        push_pixel(cx - y, cy - x, 1'b1);
        nx = (x + 1) % (1 << COORD_BITS);
        d  = dec_val;
        if (d < 0)
        begin
            d = d + 2 * nx + 1;
        end
        else
        begin
            if (y > 0)
            begin
                y = y - 1;
            end
            d = d + 2 * nx - 2 * y + 1;
        end
        off_x   = COORD_BITS'(nx);
        off_y   = COORD_BITS'(y);
        dec_val = DEC_BITS'(d);
    endtask

    task automatic predict_circle(input cmd_t c);
        pix_t p;
        if (c.cmd == CMD_BEGIN)
        begin
            org_x   = c.center_x;
            org_y   = c.center_y;
            off_x   = '0;
            off_y   = c.radius;
            dec_val = DEC_BITS'(1 - int'(c.radius));
            drawing = 1'b1;
            plot_and_advance();
        end
        else if (drawing && off_x <= off_y)
        begin
            plot_and_advance();
        end
        else
        begin
            drawing        = 1'b0;
            p              = '0;
            p.last_of_step = 1'b1;
            p.circle_done  = 1'b1;
            expected_pixels.push_back(p);
        end
    endtask

    task automatic check_pixel(input pix_t got);
        pix_t want;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected pixel transaction: x=%0d y=%0d last=%0b done=%0b",
                         got.pixel_x, got.pixel_y, got.last_of_step, got.circle_done);
            end
        end
        else
        begin
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y
                || got.last_of_step !== want.last_of_step
                || got.circle_done !== want.circle_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("pixel mismatch at %0t: exp x=%0d y=%0d last=%0b done=%0b",
                             $realtime, want.pixel_x, want.pixel_y, want.last_of_step,
                             want.circle_done);
                    $display("                      got x=%0d y=%0d last=%0b done=%0b",
                             got.pixel_x, got.pixel_y, got.last_of_step, got.circle_done);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x      = '0;
            org_y      = '0;
            off_x      = '0;
            off_y      = '0;
            dec_val    = '0;
            drawing    = 1'b0;
            mismatches = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                check_pixel(pix_data);
            end
            if (cmd_valid && cmd_ready)
            begin
                predict_circle(cmd_data);
            end
        end
        pending = expected_pixels.size();
    end

endmodule

@@ tb/sv/tb_midpoint_circle_rasterizer_top.sv @@
`timescale 1ns / 1ps

module tb_midpoint_circle_rasterizer_top;
    import mcr_pkg::*;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd_data  = '0;
    logic pix_valid;
    logic pix_ready = 1'b0;
    pix_t pix_data;
    logic no_idle   = 1'b0;
    int   mismatch_count;
    int   pixels_pending;
    int   sent      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    midpoint_circle_rasterizer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data)
    );

    circle_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_data   (pix_data),
        .mismatches (mismatch_count),
        .pending    (pixels_pending)
    );

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_ready <= 1'b0;
        end
        else
        begin
            pix_ready <= no_idle || ($urandom_range(0, 99) >= 34);
        end
    end

    task automatic send(input logic op, input int cx, input int cy, input int r);
        cmd_t c;
        c.cmd      = op;
        c.center_x = COORD_BITS'(cx);
        c.center_y = COORD_BITS'(cy);
        c.radius   = COORD_BITS'(r);
        if (!no_idle && $urandom_range(0, 99) < 34)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 34);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        sent++;
        no_idle <= (sent >= 120 && sent < 170);
    endtask

    // step fields are ignored by the block, so they carry noise
    task automatic send_step(input int n);
        repeat (n)
        begin
            send(CMD_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1023));
        end
    endtask

    initial
    begin
        int r;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no circle active, then again
        send_step(2);
        // zero radius: eight pixels at the center, then done twice
        send(CMD_BEGIN, 0, 0, 0);
        send_step(2);
        send(CMD_BEGIN, 1023, 1023, 1023);
        send_step(2);
        send(CMD_BEGIN, 0, 0, 1023);
        send_step(1);
        // begin interrupts the circle in progress, then run to done and past it
        send(CMD_BEGIN, 512, 300, 5);
        send_step(6);
        send(CMD_BEGIN, 1023, 0, 1);
        send_step(2);
        send(CMD_BEGIN, 0, 1023, 2);
        send_step(3);

        while (sent < 245)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                r = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 24)
                                                 : $urandom_range(0, 1023);
                send(CMD_BEGIN, $urandom_range(0, 1023), $urandom_range(0, 1023), r);
                if (r <= 24 && $urandom_range(0, 3) != 0)
                begin
                    n = r + $urandom_range(1, 3);
                end
                else
                begin
                    n = $urandom_range(0, 10);
                end
                send_step(n);
            end
            else if ($urandom_range(0, 1) == 1)
            begin
                send_step(1);
            end
            else
            begin
                send(CMD_BEGIN, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
            end
        end
        cmd_valid <= 1'b0;

        while (pixels_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pixels_pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
